FILE: rtl/bbd_pkg.sv
// Shared types, register indexes and constants for the binary boundary detector.
`default_nettype none

package bbd_pkg;

    localparam int unsigned DIM_MIN       = 3;
    localparam int unsigned DIM_LIMIT     = 1024;
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned CFG_W         = 11;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned COORD_W       = 10;
    localparam int unsigned PIX_W         = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic [COORD_W-1:0] w_last;
        logic [COORD_W-1:0] h_last;
        logic               outer_mode;
    } cfg_t;

    // one column of the two line buffers
    typedef struct packed {
        logic above;
        logic center;
    } col_word_t;

    typedef enum logic [1:0] {
        ST_FETCH_L,
        ST_FETCH_C,
        ST_FETCH_R,
        ST_RUN
    } state_t;

    function automatic int unsigned line_depth(input int unsigned max_width);
        return (max_width < DIM_LIMIT) ? max_width : DIM_LIMIT;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/binary_boundary_detect.sv
// An accepted request passes the input stage, then the result register, to reach m_*.
// One pixel per cycle outside reloads and m_* stalls; row 0 of each frame yields no result.
// The line buffer is one memory with one write and one registered read per cycle;
// the neighbour window runs one column ahead of the pixel being judged.
// Reset (synchronous, aresetn low) clears counters and flags; after reset and
// each frame_width write, a window reload (FETCH_L/C/R) runs before pixels are judged.
`default_nettype none

module binary_boundary_detect #(
    parameter  int unsigned MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF,
    localparam int unsigned DEPTH     = bbd_pkg::line_depth(MAX_WIDTH),
    localparam int unsigned AW        = $clog2(DEPTH)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbd_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [bbd_pkg::PIX_W-1:0]      s_pixel_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [bbd_pkg::COORD_W-1:0]         m_center_x,
    output logic [bbd_pkg::COORD_W-1:0]         m_center_y,
    output logic                                m_is_outline,
    output logic                                m_frame_done
);

    localparam int unsigned XW = bbd_pkg::COORD_W;

    bbd_pkg::cfg_t      cfg;
    logic               width_wr;

    bbd_pkg::state_t    state_reg;
    bbd_pkg::state_t    state_next;

    logic               st_valid_reg;
    logic               st_pix_reg;
    logic [XW-1:0]      column_count_reg;
    logic [XW-1:0]      row_count_reg;

    bbd_pkg::col_word_t cur_reg;
    bbd_pkg::col_word_t saved0_reg;
    bbd_pkg::col_word_t saved1_reg;
    logic               left_reg;
    logic               wrap_reg;

    logic               m_valid_reg;
    logic [XW-1:0]      m_center_x_reg;
    logic [XW-1:0]      m_center_y_reg;
    logic               m_is_outline_reg;
    logic               m_frame_done_reg;

    logic [XW-1:0]      x_eff;
    logic [XW-1:0]      y_eff;
    logic               last_col;
    logic               last_row;
    logic               process;
    logic               emit;
    logic               judge_en;
    logic               flag;

    bbd_pkg::col_word_t nxt;
    bbd_pkg::col_word_t rd_data;
    bbd_pkg::col_word_t wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    bbd_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .width_wr  (width_wr)
    );

    bbd_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (process),
        .wr_addr (x_eff[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // counters may sit beyond a frame that shrank while idle
    assign x_eff    = (column_count_reg > cfg.w_last) ? cfg.w_last : column_count_reg;
    assign y_eff    = (row_count_reg > cfg.h_last) ? cfg.h_last : row_count_reg;
    assign last_col = (x_eff == cfg.w_last);
    assign last_row = (y_eff == cfg.h_last);

    assign process  = st_valid_reg && (state_reg == bbd_pkg::ST_RUN)
                      && (!m_valid_reg || m_ready);
    assign emit     = process && (y_eff != '0);
    assign s_ready  = !st_valid_reg || process;

    assign nxt          = wrap_reg ? saved1_reg : rd_data;
    assign wr_data.above  = cur_reg.center;
    assign wr_data.center = st_pix_reg;
    assign judge_en     = (x_eff != '0) && !last_col && (y_eff > XW'(1));

    bbd_judge u_judge (
        .judge_en   (judge_en),
        .outer_mode (cfg.outer_mode),
        .center     (cur_reg.center),
        .up         (cur_reg.above),
        .down       (st_pix_reg),
        .left       (left_reg),
        .right      (nxt.center),
        .is_outline (flag)
    );

    // window reload sequencer
    always_comb begin
        unique case (state_reg)
            bbd_pkg::ST_FETCH_L: state_next = bbd_pkg::ST_FETCH_C;
            bbd_pkg::ST_FETCH_C: state_next = bbd_pkg::ST_FETCH_R;
            bbd_pkg::ST_FETCH_R: state_next = bbd_pkg::ST_RUN;
            bbd_pkg::ST_RUN:     state_next = bbd_pkg::ST_RUN;
            default:             state_next = bbd_pkg::ST_FETCH_L;
        endcase
        if (width_wr) begin
            state_next = bbd_pkg::ST_FETCH_L;
        end
    end

    always_comb begin
        unique case (state_reg)
            bbd_pkg::ST_FETCH_L: begin
                rd_en   = 1'b1;
                rd_addr = AW'(x_eff - XW'(1));
            end
            bbd_pkg::ST_FETCH_C: begin
                rd_en   = 1'b1;
                rd_addr = AW'(x_eff);
            end
            bbd_pkg::ST_FETCH_R: begin
                rd_en   = 1'b1;
                rd_addr = AW'(x_eff + XW'(1));
            end
            bbd_pkg::ST_RUN: begin
                rd_en   = process && !last_col;
                rd_addr = AW'(x_eff + XW'(2));
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbd_pkg::ST_FETCH_L;
        end else begin
            state_reg <= state_next;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            st_pix_reg <= (s_pixel_value != '0);
        end
    end

    // raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (process) begin
            if (last_col) begin
                column_count_reg <= '0;
                row_count_reg    <= last_row ? '0 : XW'(y_eff + XW'(1));
            end else begin
                column_count_reg <= XW'(x_eff + XW'(1));
                row_count_reg    <= y_eff;
            end
        end
    end

    // neighbour window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= 1'b0;
        end else if (state_reg != bbd_pkg::ST_RUN) begin
            wrap_reg <= 1'b0;
        end else if (process) begin
            wrap_reg <= last_col;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bbd_pkg::ST_FETCH_C: left_reg <= rd_data.above;
            bbd_pkg::ST_FETCH_R: cur_reg  <= rd_data;
            bbd_pkg::ST_RUN: begin
                if (process) begin
                    left_reg <= cur_reg.center;
                    cur_reg  <= last_col ? saved0_reg : nxt;
                    if (x_eff == XW'(0)) begin
                        saved0_reg <= wr_data;
                    end
                    if (x_eff == XW'(1)) begin
                        saved1_reg <= wr_data;
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_center_x_reg   <= x_eff;
            m_center_y_reg   <= XW'(y_eff - XW'(1));
            m_is_outline_reg <= flag;
            m_frame_done_reg <= last_col && last_row;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_center_x   = m_center_x_reg;
    assign m_center_y   = m_center_y_reg;
    assign m_is_outline = m_is_outline_reg;
    assign m_frame_done = m_frame_done_reg;

    a_reload_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbd_pkg::ST_FETCH_L) && !width_wr |=> (state_reg == bbd_pkg::ST_FETCH_C))
        else $error("window reload skipped a step");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        process && last_col |=> (column_count_reg == '0) && wrap_reg)
        else $error("column counter did not wrap at row end");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        process && !last_col |=> (column_count_reg == XW'($past(x_eff) + XW'(1))) && !wrap_reg)
        else $error("column counter did not advance");

    a_stage_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> st_valid_reg)
        else $error("accepted request lost from input stage");

    a_emit_row: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid && (m_center_y == XW'($past(y_eff) - XW'(1))))
        else $error("result row does not trail the incoming row");

endmodule

`default_nettype wire

FILE: rtl/bbd_cfg_regs.sv
// Configuration registers with frame size saturation.
`default_nettype none

module bbd_cfg_regs #(
    parameter int unsigned MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbd_pkg::CFG_W-1:0]      cfg_wdata,
    output bbd_pkg::cfg_t                       cfg,
    output logic                                width_wr
);

    localparam int unsigned CW   = bbd_pkg::CFG_W;
    localparam int unsigned XW   = bbd_pkg::COORD_W;
    localparam int unsigned WLIM = bbd_pkg::line_depth(MAX_WIDTH);

    localparam logic [CW-1:0] D_MIN = CW'(bbd_pkg::DIM_MIN);
    localparam logic [CW-1:0] W_MAX = CW'(WLIM);
    localparam logic [CW-1:0] H_MAX = CW'(bbd_pkg::DIM_LIMIT);

    logic [CW-1:0] frame_width_reg;
    logic [CW-1:0] frame_height_reg;
    logic          outer_mode_reg;
    logic [CW-1:0] width_sat;
    logic [CW-1:0] height_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bbd_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bbd_pkg::FRAME_HEIGHT_RST;
            outer_mode_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bbd_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                bbd_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                bbd_pkg::CFG_OUTER_MODE:   outer_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (frame_width_reg < D_MIN) begin
            width_sat = D_MIN;
        end else if (frame_width_reg > W_MAX) begin
            width_sat = W_MAX;
        end else begin
            width_sat = frame_width_reg;
        end
        priority if (frame_height_reg < D_MIN) begin
            height_sat = D_MIN;
        end else if (frame_height_reg > H_MAX) begin
            height_sat = H_MAX;
        end else begin
            height_sat = frame_height_reg;
        end
    end

    assign cfg.w_last     = XW'(width_sat - CW'(1));
    assign cfg.h_last     = XW'(height_sat - CW'(1));
    assign cfg.outer_mode = outer_mode_reg;
    assign width_wr       = cfg_wr_en && (cfg_index == bbd_pkg::CFG_FRAME_WIDTH);

endmodule

`default_nettype wire

FILE: rtl/bbd_line_buf.sv
// Two one-bit line buffers held as one two-bit word per column, registered read.
`default_nettype none

module bbd_line_buf #(
    parameter  int unsigned MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF,
    localparam int unsigned DEPTH     = bbd_pkg::line_depth(MAX_WIDTH),
    localparam int unsigned AW        = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire bbd_pkg::col_word_t wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output bbd_pkg::col_word_t      rd_data
);

    bbd_pkg::col_word_t mem [DEPTH];
    bbd_pkg::col_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/bbd_judge.sv
// Four-neighbour outline rule, inner and outer forms.
`default_nettype none

module bbd_judge (
    input  wire logic           judge_en,
    input  wire logic           outer_mode,
    input  wire logic           center,
    input  wire logic           up,
    input  wire logic           down,
    input  wire logic           left,
    input  wire logic           right,
    output logic                is_outline
);

    logic any_empty;
    logic any_occupied;

    assign any_empty    = !up || !down || !left || !right;
    assign any_occupied = up || down || left || right;

    always_comb begin
        if (!judge_en) begin
            is_outline = 1'b0;
        end else if (outer_mode) begin
            is_outline = !center && any_occupied;
        end else begin
            is_outline = center && any_empty;
        end
    end

endmodule

`default_nettype wire
